>>> hw/rtl/triangle_plane_height_defines.svh
// Assertion macros for the triangle plane height RTL.
`ifndef TRIANGLE_PLANE_HEIGHT_DEFINES_SVH
`define TRIANGLE_PLANE_HEIGHT_DEFINES_SVH

// The condition must never hold while out of reset.
`define TPH_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define TPH_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TPH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/tph_pkg.sv
// Shared codes and types for the triangle plane height block.
package tph_pkg;

    typedef enum logic [1:0] {
        FUNC_Y    = 2'd0,
        FUNC_Z    = 2'd1,
        FUNC_X    = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DEGEN = 2'd1,
        ST_SAT   = 2'd2
    } status_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_flags_t;

endpackage

>>> hw/rtl/triangle_plane_height.sv
// Top level of the triangle plane height block.
//
//   Channel   Direction  Handshake         Payload
//   input     in         push / full       func, point_u/v, vertex_a..c x/y/z
//   result    out        pop / empty       solved_coord, status
//
// One item enters per cycle while full is low; each result reaches the ports after its transfer
// through the front's six stages, the queue's one, the divider's W + 3
// (a load stage, then one quotient bit per stage), and two more for rounding and clamping.
// Reset clears all valid bits and the queue pointers; no clearing pass is needed.
// A result not popped stalls the back pipeline; the queue then fills and raises full.
`include "triangle_plane_height_defines.svh"

module triangle_plane_height #(
    parameter int COORD_WIDTH = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [1:0]              func,
    input  logic [COORD_WIDTH-1:0]  point_u,
    input  logic [COORD_WIDTH-1:0]  point_v,
    input  logic [COORD_WIDTH-1:0]  vertex_a_x,
    input  logic [COORD_WIDTH-1:0]  vertex_a_y,
    input  logic [COORD_WIDTH-1:0]  vertex_a_z,
    input  logic [COORD_WIDTH-1:0]  vertex_b_x,
    input  logic [COORD_WIDTH-1:0]  vertex_b_y,
    input  logic [COORD_WIDTH-1:0]  vertex_b_z,
    input  logic [COORD_WIDTH-1:0]  vertex_c_x,
    input  logic [COORD_WIDTH-1:0]  vertex_c_y,
    input  logic [COORD_WIDTH-1:0]  vertex_c_z,
    output logic                    empty,
    input  logic                    pop,
    output logic [COORD_WIDTH-1:0]  solved_coord,
    output logic [1:0]              status
);
    localparam int W  = COORD_WIDTH;
    localparam int NB = 3 * W + 3;
    localparam int MW = 2 * W + 2;
    localparam int PL = 2 + NB + MW + W;

    logic                f_adv, f_valid, f_bad, f_neg;
    logic [NB-1:0]       f_num;
    logic [MW-1:0]       f_den;
    logic [W-1:0]        f_as;
    tph_pkg::q_flags_t   q_flags;
    logic [PL-1:0]       q_rd;
    logic                b_adv;

    tph_front #(.W(W), .NB(NB), .MW(MW)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (push),
        .func       (func),
        .point_u    (point_u),
        .point_v    (point_v),
        .vertex_a_x (vertex_a_x),
        .vertex_a_y (vertex_a_y),
        .vertex_a_z (vertex_a_z),
        .vertex_b_x (vertex_b_x),
        .vertex_b_y (vertex_b_y),
        .vertex_b_z (vertex_b_z),
        .vertex_c_x (vertex_c_x),
        .vertex_c_y (vertex_c_y),
        .vertex_c_z (vertex_c_z),
        .q_flags    (q_flags),
        .adv        (f_adv),
        .out_valid  (f_valid),
        .out_bad    (f_bad),
        .out_neg    (f_neg),
        .out_num    (f_num),
        .out_den    (f_den),
        .out_as     (f_as)
    );

    assign full = !f_adv;

    tph_queue #(.WIDTH(PL), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_valid && f_adv),
        .wr_data ({f_bad, f_neg, f_num, f_den, f_as}),
        .rd_en   (b_adv),
        .rd_data (q_rd),
        .flags   (q_flags)
    );

    tph_back #(.W(W), .NB(NB), .MW(MW)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (!q_flags.empty),
        .in_bad       (q_rd[PL-1]),
        .in_neg       (q_rd[PL-2]),
        .in_num       (q_rd[PL-3 -: NB]),
        .in_den       (q_rd[W+MW-1 -: MW]),
        .in_as        (q_rd[W-1:0]),
        .pop          (pop),
        .adv          (b_adv),
        .empty        (empty),
        .solved_coord (solved_coord),
        .status       (status)
    );

    `TPH_ASSERT_NEVER(a_queue_flags, q_flags.full && q_flags.empty, "queue both full and empty")
    `TPH_ASSERT_NEVER(a_status_code, !empty && status > tph_pkg::ST_SAT, "bad status code")
    `TPH_ASSERT_IMPL(a_degen_zero, !empty && status == tph_pkg::ST_DEGEN, solved_coord == '0, "degen")
    `TPH_ASSERT_NEXT(a_front_stall, f_valid && q_flags.full, f_valid, "front lost an item")

endmodule

>>> hw/rtl/tph_front.sv
// Front pipeline: edges, face normal, numerator and sign of the quotient.
module tph_front #(
    parameter int W = 32,
    parameter int NB = 3 * W + 3,
    parameter int MW = 2 * W + 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          func,
    input  logic [W-1:0]        point_u,
    input  logic [W-1:0]        point_v,
    input  logic [W-1:0]        vertex_a_x,
    input  logic [W-1:0]        vertex_a_y,
    input  logic [W-1:0]        vertex_a_z,
    input  logic [W-1:0]        vertex_b_x,
    input  logic [W-1:0]        vertex_b_y,
    input  logic [W-1:0]        vertex_b_z,
    input  logic [W-1:0]        vertex_c_x,
    input  logic [W-1:0]        vertex_c_y,
    input  logic [W-1:0]        vertex_c_z,
    input  tph_pkg::q_flags_t   q_flags,
    output logic                adv,
    output logic                out_valid,
    output logic                out_bad,
    output logic                out_neg,
    output logic [NB-1:0]       out_num,
    output logic [MW-1:0]       out_den,
    output logic [W-1:0]        out_as
);
    localparam int EW = W + 1;
    localparam int PW = 2 * EW;
    localparam int NW = PW + 1;
    localparam int TW = 3 * EW + 1;
    localparam int SW = 3 * EW + 2;

    logic [6:1] v_reg;

    // Stage 1: edges and point offsets.
    tph_pkg::func_t          f1_reg;
    logic signed [EW-1:0]    e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;
    logic signed [EW-1:0]    du1_reg, dv1_reg;
    logic [W-1:0]            as1_reg;
    logic signed [EW-1:0]    du_next, dv_next;
    logic [W-1:0]            as_next;

    // Stage 2: cross product terms.
    tph_pkg::func_t          f2_reg;
    logic signed [PW-1:0]    p_yz_reg, p_zy_reg, p_zx_reg, p_xz_reg, p_xy_reg, p_yx_reg;
    logic signed [EW-1:0]    du2_reg, dv2_reg;
    logic [W-1:0]            as2_reg;

    // Stage 3: normal components picked by axis.
    logic                    bad3_reg;
    logic signed [NW-1:0]    nu_reg, nv_reg, ns_reg;
    logic signed [EW-1:0]    du3_reg, dv3_reg;
    logic [W-1:0]            as3_reg;
    logic signed [NW-1:0]    nx, ny, nz, nu_next, nv_next, ns_next;

    // Stage 4: split partial products on magnitudes.
    logic                    bad4_reg, su4_reg, sv4_reg, sn4_reg;
    logic [PW-1:0]           uhi_reg, ulo_reg, vhi_reg, vlo_reg;
    logic [MW-1:0]           den4_reg;
    logic [W-1:0]            as4_reg;
    logic signed [NW-1:0]    nu_abs, nv_abs, ns_abs;
    logic signed [EW-1:0]    du_abs, dv_abs;
    logic [MW-1:0]           nu_mag, nv_mag;
    logic [EW-1:0]           du_mag, dv_mag;

    // Stage 5: signed product terms.
    logic                    bad5_reg, sn5_reg;
    logic signed [TW-1:0]    tu_reg, tv_reg;
    logic [MW-1:0]           den5_reg;
    logic [W-1:0]            as5_reg;
    logic [3*EW-1:0]         tu_mag, tv_mag;

    // Stage 6: numerator magnitude and quotient sign.
    logic                    bad6_reg, neg6_reg;
    logic [NB-1:0]           num6_reg;
    logic [MW-1:0]           den6_reg;
    logic [W-1:0]            as6_reg;
    logic signed [SW-1:0]    sum, sum_abs;
    logic                    num_neg;

    assign adv = !v_reg[6] || !q_flags.full;

    always_comb
    begin
        unique case (tph_pkg::func_t'(func))
            tph_pkg::FUNC_Z:
            begin
                du_next = $signed({point_u[W-1], point_u}) - $signed({vertex_a_x[W-1], vertex_a_x});
                dv_next = $signed({point_v[W-1], point_v}) - $signed({vertex_a_y[W-1], vertex_a_y});
                as_next = vertex_a_z;
            end
            tph_pkg::FUNC_X:
            begin
                du_next = $signed({point_u[W-1], point_u}) - $signed({vertex_a_y[W-1], vertex_a_y});
                dv_next = $signed({point_v[W-1], point_v}) - $signed({vertex_a_z[W-1], vertex_a_z});
                as_next = vertex_a_x;
            end
            default:
            begin
                du_next = $signed({point_u[W-1], point_u}) - $signed({vertex_a_x[W-1], vertex_a_x});
                dv_next = $signed({point_v[W-1], point_v}) - $signed({vertex_a_z[W-1], vertex_a_z});
                as_next = vertex_a_y;
            end
        endcase
    end

    always_comb
    begin
        nx = NW'(p_yz_reg) - NW'(p_zy_reg);
        ny = NW'(p_zx_reg) - NW'(p_xz_reg);
        nz = NW'(p_xy_reg) - NW'(p_yx_reg);
        unique case (f2_reg)
            tph_pkg::FUNC_Z:
            begin
                nu_next = nx;
                nv_next = ny;
                ns_next = nz;
            end
            tph_pkg::FUNC_X:
            begin
                nu_next = ny;
                nv_next = nz;
                ns_next = nx;
            end
            default:
            begin
                nu_next = nx;
                nv_next = nz;
                ns_next = ny;
            end
        endcase
    end

    always_comb
    begin
        nu_abs = nu_reg[NW-1] ? -nu_reg : nu_reg;
        nv_abs = nv_reg[NW-1] ? -nv_reg : nv_reg;
        ns_abs = ns_reg[NW-1] ? -ns_reg : ns_reg;
        du_abs = du3_reg[EW-1] ? -du3_reg : du3_reg;
        dv_abs = dv3_reg[EW-1] ? -dv3_reg : dv3_reg;
        nu_mag = nu_abs[MW-1:0];
        nv_mag = nv_abs[MW-1:0];
        du_mag = du_abs;
        dv_mag = dv_abs;
    end

    always_comb
    begin
        tu_mag = {uhi_reg, {EW{1'b0}}} + {{EW{1'b0}}, ulo_reg};
        tv_mag = {vhi_reg, {EW{1'b0}}} + {{EW{1'b0}}, vlo_reg};
    end

    always_comb
    begin
        sum     = SW'(tu_reg) + SW'(tv_reg);
        sum_abs = sum[SW-1] ? -sum : sum;
        // The numerator is the negated sum of the two terms.
        num_neg = !sum[SW-1] && (sum != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[5:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg  <= tph_pkg::func_t'(func);
            e1x_reg <= $signed({vertex_b_x[W-1], vertex_b_x}) - $signed({vertex_a_x[W-1], vertex_a_x});
            e1y_reg <= $signed({vertex_b_y[W-1], vertex_b_y}) - $signed({vertex_a_y[W-1], vertex_a_y});
            e1z_reg <= $signed({vertex_b_z[W-1], vertex_b_z}) - $signed({vertex_a_z[W-1], vertex_a_z});
            e2x_reg <= $signed({vertex_c_x[W-1], vertex_c_x}) - $signed({vertex_a_x[W-1], vertex_a_x});
            e2y_reg <= $signed({vertex_c_y[W-1], vertex_c_y}) - $signed({vertex_a_y[W-1], vertex_a_y});
            e2z_reg <= $signed({vertex_c_z[W-1], vertex_c_z}) - $signed({vertex_a_z[W-1], vertex_a_z});
            du1_reg <= du_next;
            dv1_reg <= dv_next;
            as1_reg <= as_next;

            f2_reg   <= f1_reg;
            p_yz_reg <= e1y_reg * e2z_reg;
            p_zy_reg <= e1z_reg * e2y_reg;
            p_zx_reg <= e1z_reg * e2x_reg;
            p_xz_reg <= e1x_reg * e2z_reg;
            p_xy_reg <= e1x_reg * e2y_reg;
            p_yx_reg <= e1y_reg * e2x_reg;
            du2_reg  <= du1_reg;
            dv2_reg  <= dv1_reg;
            as2_reg  <= as1_reg;

            bad3_reg <= (f2_reg == tph_pkg::FUNC_NONE);
            nu_reg   <= nu_next;
            nv_reg   <= nv_next;
            ns_reg   <= ns_next;
            du3_reg  <= du2_reg;
            dv3_reg  <= dv2_reg;
            as3_reg  <= as2_reg;

            bad4_reg <= bad3_reg || (ns_reg == '0);
            su4_reg  <= nu_reg[NW-1] ^ du3_reg[EW-1];
            sv4_reg  <= nv_reg[NW-1] ^ dv3_reg[EW-1];
            sn4_reg  <= ns_reg[NW-1];
            uhi_reg  <= nu_mag[MW-1:EW] * du_mag;
            ulo_reg  <= nu_mag[EW-1:0] * du_mag;
            vhi_reg  <= nv_mag[MW-1:EW] * dv_mag;
            vlo_reg  <= nv_mag[EW-1:0] * dv_mag;
            den4_reg <= ns_abs[MW-1:0];
            as4_reg  <= as3_reg;

            bad5_reg <= bad4_reg;
            sn5_reg  <= sn4_reg;
            tu_reg   <= su4_reg ? -$signed({1'b0, tu_mag}) : $signed({1'b0, tu_mag});
            tv_reg   <= sv4_reg ? -$signed({1'b0, tv_mag}) : $signed({1'b0, tv_mag});
            den5_reg <= den4_reg;
            as5_reg  <= as4_reg;

            bad6_reg <= bad5_reg;
            neg6_reg <= num_neg ^ sn5_reg;
            num6_reg <= sum_abs[NB-1:0];
            den6_reg <= den5_reg;
            as6_reg  <= as5_reg;
        end
    end

    assign out_valid = v_reg[6];
    assign out_bad   = bad6_reg;
    assign out_neg   = neg6_reg;
    assign out_num   = num6_reg;
    assign out_den   = den6_reg;
    assign out_as    = as6_reg;

endmodule

>>> hw/rtl/tph_queue.sv
// Small register queue between the front and back pipelines.
module tph_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [WIDTH-1:0]    wr_data,
    input  logic                rd_en,
    output logic [WIDTH-1:0]    rd_data,
    output tph_pkg::q_flags_t   flags
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [CW-1:0]    cnt_reg;
    logic             do_wr, do_rd;

    assign do_wr = wr_en && (cnt_reg != CW'(DEPTH));
    assign do_rd = rd_en && (cnt_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= (wp_reg == LAST) ? '0 : wp_reg + AW'(1);
            end
            if (do_rd)
            begin
                rp_reg <= (rp_reg == LAST) ? '0 : rp_reg + AW'(1);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    assign rd_data     = mem_reg[rp_reg];
    assign flags.full  = (cnt_reg == CW'(DEPTH));
    assign flags.empty = (cnt_reg == '0);

endmodule

>>> hw/rtl/tph_back.sv
// Back pipeline: restoring divider one quotient bit a stage, rounding and clamping.
module tph_back #(
    parameter int W = 32,
    parameter int NB = 3 * W + 3,
    parameter int MW = 2 * W + 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_bad,
    input  logic            in_neg,
    input  logic [NB-1:0]   in_num,
    input  logic [MW-1:0]   in_den,
    input  logic [W-1:0]    in_as,
    input  logic            pop,
    output logic            adv,
    output logic            empty,
    output logic [W-1:0]    solved_coord,
    output logic [1:0]      status
);
    localparam int NS = W + 2;
    localparam int QW = W + 2;
    localparam int RW = W + 4;

    logic [NS:0]         v_reg;
    logic [NB-1:0]       r_reg   [NS+1];
    logic [MW-1:0]       d_reg   [NS+1];
    logic [QW-1:0]       q_reg   [NS+1];
    logic [W-1:0]        as_reg  [NS+1];
    logic [NS:0]         neg_reg, bad_reg, sat_reg;

    logic                vr_reg, badr_reg, satr_reg, negr_reg;
    logic signed [RW-1:0] qs_reg;
    logic [W-1:0]        asr_reg;

    logic                vo_reg;
    logic [W-1:0]        coord_reg;
    tph_pkg::status_t    status_reg;

    logic                rnd;
    logic [QW:0]         q_rnd;
    logic signed [RW-1:0] res;
    logic signed [RW-1:0] lim_hi, lim_lo;
    logic [W-1:0]        sat_val;

    assign adv = !vo_reg || pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            vr_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg  <= {v_reg[NS-1:0], in_valid};
            vr_reg <= v_reg[NS];
            vo_reg <= vr_reg;
        end
    end

    // Quotient bits at weight 2^(W+2) and above only mean saturation.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg[0]   <= in_num;
            d_reg[0]   <= in_den;
            q_reg[0]   <= '0;
            as_reg[0]  <= in_as;
            neg_reg[0] <= in_neg;
            bad_reg[0] <= in_bad;
            sat_reg[0] <= (NB + 1)'(in_num) >= ((NB + 1)'(in_den) << (W + 2));
        end
    end

    for (genvar i = 1; i <= NS; i++)
    begin : g_div
        localparam int K = NS - i;
        logic [NB-1:0] dsh;
        logic          take;

        assign dsh  = NB'(d_reg[i-1]) << K;
        assign take = (r_reg[i-1] >= dsh);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                r_reg[i]   <= take ? r_reg[i-1] - dsh : r_reg[i-1];
                q_reg[i]   <= take ? q_reg[i-1] | (QW'(1) << K) : q_reg[i-1];
                d_reg[i]   <= d_reg[i-1];
                as_reg[i]  <= as_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
                bad_reg[i] <= bad_reg[i-1];
                sat_reg[i] <= sat_reg[i-1];
            end
        end
    end

    // Round to nearest with ties away from zero: twice the remainder against the divisor.
    always_comb
    begin
        rnd   = ({r_reg[NS], 1'b0} >= (NB + 1)'(d_reg[NS]));
        q_rnd = (QW + 1)'(q_reg[NS]) + (QW + 1)'(rnd);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            badr_reg <= bad_reg[NS];
            satr_reg <= sat_reg[NS];
            negr_reg <= neg_reg[NS];
            qs_reg   <= neg_reg[NS] ? -$signed(RW'(q_rnd)) : $signed(RW'(q_rnd));
            asr_reg  <= as_reg[NS];
        end
    end

    always_comb
    begin
        lim_hi  = RW'({1'b0, {(W-1){1'b1}}});
        lim_lo  = -lim_hi - RW'(1);
        res     = $signed({{(RW-W){asr_reg[W-1]}}, asr_reg}) + qs_reg;
        sat_val = {1'b0, {(W-1){1'b1}}};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            priority if (badr_reg)
            begin
                coord_reg  <= '0;
                status_reg <= tph_pkg::ST_DEGEN;
            end
            else if (satr_reg)
            begin
                coord_reg  <= negr_reg ? ~sat_val : sat_val;
                status_reg <= tph_pkg::ST_SAT;
            end
            else if (res > lim_hi)
            begin
                coord_reg  <= sat_val;
                status_reg <= tph_pkg::ST_SAT;
            end
            else if (res < lim_lo)
            begin
                coord_reg  <= ~sat_val;
                status_reg <= tph_pkg::ST_SAT;
            end
            else
            begin
                coord_reg  <= res[W-1:0];
                status_reg <= tph_pkg::ST_OK;
            end
        end
    end

    assign empty        = !vo_reg;
    assign solved_coord = coord_reg;
    assign status       = status_reg;

endmodule
